/* rtl/assert_macros.svh */
// Assertion helpers. Both sample on clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, cond, msg)

`define ASSERT_IMPLIES(label, ante, cons, msg)

`endif

`endif

/* rtl/xdiv_pkg.sv */
package xdiv_pkg;

    localparam int WORD_BITS      = 32;
    localparam int BITS_PER_STAGE = 4;
    localparam int NUM_STAGES     = WORD_BITS / BITS_PER_STAGE;

    localparam logic [WORD_BITS-1:0] SIGN_LIMIT = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef logic [WORD_BITS-1:0] word_t;

    // Payload carried down the divider pipeline.
    typedef struct packed {
        word_t rem;        // partial remainder, below dmag unless err is set
        word_t quo;        // dividend low bits shifting out, quotient bits shifting in
        word_t dmag;       // divisor magnitude
        word_t orig_high;
        word_t orig_low;
        logic  is_signed;
        logic  nneg;       // dividend negative (signed only)
        logic  qneg;       // quotient negative (signed only)
        logic  err;        // zero divisor or high word too large
    } stage_t;

endpackage

/* rtl/xdiv_pre.sv */
module xdiv_pre (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             func,
    input  xdiv_pkg::word_t  dividend_high,
    input  xdiv_pkg::word_t  dividend_low,
    input  xdiv_pkg::word_t  divisor,
    output logic             out_valid,
    input  logic             out_ready,
    output xdiv_pkg::stage_t out_data
);
    import xdiv_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    stage_t                 data_reg;
    stage_t                 data_next;
    logic [2*WORD_BITS-1:0] num;
    logic [2*WORD_BITS-1:0] nmag;
    logic                   nneg;
    logic                   dneg;
    word_t                  dmag;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        num  = {dividend_high, dividend_low};
        nneg = func & dividend_high[WORD_BITS-1];
        dneg = func & divisor[WORD_BITS-1];
        nmag = nneg ? (~num + {{(2*WORD_BITS-1){1'b0}}, 1'b1}) : num;
        dmag = dneg ? (~divisor + {{(WORD_BITS-1){1'b0}}, 1'b1}) : divisor;

        data_next.rem       = nmag[2*WORD_BITS-1:WORD_BITS];
        data_next.quo       = nmag[WORD_BITS-1:0];
        data_next.dmag      = dmag;
        data_next.orig_high = dividend_high;
        data_next.orig_low  = dividend_low;
        data_next.is_signed = func;
        data_next.nneg      = nneg;
        data_next.qneg      = nneg ^ dneg;
        // quotient needs more than a word when the high part is not below the divisor
        data_next.err       = (divisor == '0) || (nmag[2*WORD_BITS-1:WORD_BITS] >= dmag);

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/xdiv_step.sv */
module xdiv_step (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  xdiv_pkg::stage_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output xdiv_pkg::stage_t out_data
);
    import xdiv_pkg::*;

    logic           valid_reg;
    logic           valid_next;
    stage_t         data_reg;
    stage_t         data_next;
    word_t          rem;
    word_t          quo;
    logic [WORD_BITS:0] trial;
    logic [WORD_BITS:0] diff;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // restoring division, BITS_PER_STAGE quotient bits per stage
    always_comb
    begin
        rem = in_data.rem;
        quo = in_data.quo;
        trial = '0;
        diff  = '0;
        for (int k = 0; k < BITS_PER_STAGE; k++)
        begin
            trial = {rem, quo[WORD_BITS-1]};
            diff  = trial - {1'b0, in_data.dmag};
            if (!diff[WORD_BITS])
            begin
                rem = diff[WORD_BITS-1:0];
                quo = {quo[WORD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem = trial[WORD_BITS-1:0];
                quo = {quo[WORD_BITS-2:0], 1'b0};
            end
        end
        data_next     = in_data;
        data_next.rem = rem;
        data_next.quo = quo;

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/xdiv_post.sv */
module xdiv_post (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  xdiv_pkg::stage_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output xdiv_pkg::word_t  quotient,
    output xdiv_pkg::word_t  remainder,
    output logic             divide_error
);
    import xdiv_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    word_t quotient_reg;
    word_t quotient_next;
    word_t remainder_reg;
    word_t remainder_next;
    logic  error_reg;
    logic  error_next;
    logic  ovf;

    assign in_ready     = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign quotient     = quotient_reg;
    assign remainder    = remainder_reg;
    assign divide_error = error_reg;

    always_comb
    begin
        // signed range: magnitude up to 2^31 when negative, below 2^31 otherwise
        ovf = in_data.is_signed &&
              (in_data.qneg ? (in_data.quo > SIGN_LIMIT) : in_data.quo[WORD_BITS-1]);
        error_next = in_data.err || ovf;
        if (error_next)
        begin
            quotient_next  = in_data.orig_low;
            remainder_next = in_data.orig_high;
        end
        else
        begin
            quotient_next  = in_data.qneg ? (~in_data.quo + {{(WORD_BITS-1){1'b0}}, 1'b1})
                                          : in_data.quo;
            remainder_next = in_data.nneg ? (~in_data.rem + {{(WORD_BITS-1){1'b0}}, 1'b1})
                                          : in_data.rem;
        end

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            quotient_reg  <= quotient_next;
            remainder_reg <= remainder_next;
            error_reg     <= error_next;
        end
    end

endmodule

/* rtl/x86_div_idiv_64_by_32_core.sv */
// 64-by-32 DIV/IDIV unit: one division accepted per cycle unless stalled,
// passing one sign/range stage, eight stages of four restoring-division bits each
// and one fix-up/output register. Each stage stalls only when it holds a beat
// that the next stage cannot take, so bubbles collapse and the input stays ready
// while the pipeline has room. Divide error (zero divisor or quotient out of range)
// returns the original EDX:EAX unchanged in remainder:quotient.
`include "assert_macros.svh"

module x86_div_idiv_64_by_32_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // dividend_high, dividend_low, divisor
    input  logic        s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // quotient, remainder
    output logic        m_axis_tuser    // divide_error
);
    import xdiv_pkg::*;

    stage_t pipe_data  [NUM_STAGES+1];
    logic   pipe_valid [NUM_STAGES+1];
    logic   pipe_ready [NUM_STAGES+1];
    word_t  quotient;
    word_t  remainder;

    xdiv_pre u_pre (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .func          (s_axis_tuser),
        .dividend_high (s_axis_tdata[WORD_BITS-1:0]),
        .dividend_low  (s_axis_tdata[2*WORD_BITS-1:WORD_BITS]),
        .divisor       (s_axis_tdata[3*WORD_BITS-1:2*WORD_BITS]),
        .out_valid     (pipe_valid[0]),
        .out_ready     (pipe_ready[0]),
        .out_data      (pipe_data[0])
    );

    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_step
        xdiv_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pipe_valid[i]),
            .in_ready  (pipe_ready[i]),
            .in_data   (pipe_data[i]),
            .out_valid (pipe_valid[i+1]),
            .out_ready (pipe_ready[i+1]),
            .out_data  (pipe_data[i+1])
        );
    end

    xdiv_post u_post (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pipe_valid[NUM_STAGES]),
        .in_ready     (pipe_ready[NUM_STAGES]),
        .in_data      (pipe_data[NUM_STAGES]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .quotient     (quotient),
        .remainder    (remainder),
        .divide_error (m_axis_tuser)
    );

    assign m_axis_tdata = {remainder, quotient};

    // back-pressure on the input only when the output holds a beat
    `ASSERT_IMPLIES(a_stall_needs_output, !s_axis_tready, m_axis_tvalid,
                    "input stalled with no result waiting")
    `ASSERT_IMPLIES(a_zero_div_flags, pipe_valid[0] && (pipe_data[0].dmag == '0),
                    pipe_data[0].err, "zero divisor not flagged")
    `ASSERT_IMPLIES(a_partial_rem_bound,
                    pipe_valid[NUM_STAGES] && !pipe_data[NUM_STAGES].err,
                    pipe_data[NUM_STAGES].rem < pipe_data[NUM_STAGES].dmag,
                    "remainder not below divisor")

endmodule
